// ----- hw/rtl/gncl_pkg.sv -----
// shared types, codes and helpers of the gauss-newton circle locator
package gncl_pkg;

  localparam int XY_W            = 32;
  localparam int RES_W           = 34;
  localparam int MUL_AW          = 40;
  localparam int MUL_BW          = 33;
  localparam int MUL_LO_W        = 20;
  localparam int RESULT_CAP      = 16;
  localparam int STEP_LIMIT_LOG2 = 40;
  localparam int QW              = STEP_LIMIT_LOG2 + 1;
  localparam logic [1:0] ANCHOR_LAST = 2'd2;

  typedef struct packed {
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
  } gncl_in_t;

  typedef struct packed {
    logic signed [31:0] est_x;
    logic signed [31:0] est_y;
    logic [3:0]         iteration_index;
    logic               singular;
    logic               last_result;
  } gncl_out_t;

  typedef enum logic [2:0] {
    REG_A_X  = 3'd0,
    REG_A_Y  = 3'd1,
    REG_B_X  = 3'd2,
    REG_B_Y  = 3'd3,
    REG_C_X  = 3'd4,
    REG_C_Y  = 3'd5,
    REG_RAD  = 3'd6,
    REG_ITER = 3'd7
  } gncl_reg_t;

  typedef struct packed {
    logic [2:0][31:0] ax;
    logic [2:0][31:0] ay;
    logic [30:0]      radius;
    logic [4:0]       iters;
  } gncl_cfg_t;

  typedef enum logic [4:0] {
    OP_DIFF, OP_SQX, OP_SQY, OP_ROOT, OP_JX, OP_JY,
    OP_SXX, OP_SXY, OP_SYY, OP_GX, OP_GY, OP_NORM,
    OP_DET1, OP_DET2, OP_NX1, OP_NX2, OP_DVX,
    OP_NY1, OP_NY2, OP_DVY, OP_UPD
  } gncl_op_t;

  typedef enum logic [1:0] {U_LOCAL, U_MUL, U_DIV, U_SQRT} gncl_unit_t;

  typedef enum logic [1:0] {ST_IDLE, ST_LAUNCH, ST_WAIT, ST_OUT} gncl_state_t;

  typedef struct packed {
    gncl_op_t   op;
    logic [1:0] sel;
    logic       load;
    logic       launch;
    logic       commit;
  } gncl_cmd_t;

  typedef struct packed {
    logic done;
    logic d_zero;
    logic det_zero;
  } gncl_stat_t;

  typedef struct packed {
    logic [3:0] idx;
    logic       sing;
    logic       last;
  } gncl_info_t;

  // which shared unit carries out an operation
  function automatic gncl_unit_t op_unit(input gncl_op_t op);
    gncl_unit_t u;
    case (op)
      OP_ROOT: u = U_SQRT;
      OP_JX, OP_JY, OP_DVX, OP_DVY: u = U_DIV;
      OP_DIFF, OP_NORM, OP_UPD: u = U_LOCAL;
      default: u = U_MUL;
    endcase
    return u;
  endfunction

  // saturate to 32-bit signed
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sh0000_0000_7FFF_FFFF) r = 32'sh7FFF_FFFF;
    else if (v < -64'sh0000_0000_8000_0000) r = 32'sh8000_0000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic [31:0] abs32(input logic signed [31:0] v);
    logic [31:0] r;
    r = v[31] ? 32'(-v) : 32'(v);
    return r;
  endfunction

  function automatic logic [63:0] abs64(input logic signed [63:0] v);
    logic [63:0] r;
    r = v[63] ? 64'(-v) : 64'(v);
    return r;
  endfunction

endpackage

// ----- hw/rtl/gncl_mul.sv -----
// two-pass signed multiplier built from two narrow partial products
module gncl_mul (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic signed [gncl_pkg::MUL_AW-1:0] a,
  input  logic signed [gncl_pkg::MUL_BW-1:0] b,
  output logic signed [63:0]                 p,
  output logic                               done
);
  import gncl_pkg::*;

  localparam int HI_W = MUL_AW - MUL_LO_W;

  logic signed [MUL_AW-1:0]      a_r;
  logic signed [MUL_BW-1:0]      b_r;
  logic signed [63:0]            p_r;
  logic                          busy_r, phase_r, done_r;
  logic signed [MUL_BW+MUL_LO_W:0] lo_prod;
  logic signed [MUL_BW+HI_W-1:0] hi_prod;

  // low part unsigned, high part signed
  always_comb begin
    lo_prod = b_r * $signed({1'b0, a_r[MUL_LO_W-1:0]});
    hi_prod = b_r * $signed(a_r[MUL_AW-1:MUL_LO_W]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      phase_r <= 1'b0;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r  <= 1'b1;
        phase_r <= 1'b0;
      end else if (busy_r) begin
        if (phase_r) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
        phase_r <= ~phase_r;
      end
    end
  end

  // operand capture and accumulation
  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= a;
      b_r <= b;
    end else if (busy_r) begin
      if (!phase_r) p_r <= 64'(lo_prod);
      else p_r <= p_r + (64'(hi_prod) <<< MUL_LO_W);
    end
  end

  assign p    = p_r;
  assign done = done_r;
endmodule

// ----- hw/rtl/gncl_sqrt.sv -----
// integer square root, one result bit per cycle
module gncl_sqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] v,
  output logic [31:0] root,
  output logic        done
);
  import gncl_pkg::*;

  logic [63:0] val_r;
  logic [32:0] rem_r;
  logic [31:0] root_r;
  logic [5:0]  cnt_r;
  logic        busy_r, done_r;
  logic [34:0] rem_sh, trial, diff;
  logic        ge;

  // bring down two bits and try the next root bit
  always_comb begin
    rem_sh = {rem_r, val_r[63:62]};
    trial  = {1'b0, root_r, 2'b01};
    ge     = rem_sh >= trial;
    diff   = rem_sh - trial;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 6'd32;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      val_r  <= v;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      val_r  <= {val_r[61:0], 2'b00};
      rem_r  <= ge ? diff[32:0] : rem_sh[32:0];
      root_r <= {root_r[30:0], ge};
    end
  end

  assign root = root_r;
  assign done = done_r;
endmodule

// ----- hw/rtl/gncl_div.sv -----
// restoring divider for floor(n * 2^F / d), quotient saturated at the step limit
module gncl_div #(
  parameter int FRAC_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic                    short_mode,
  input  logic [63:0]             n,
  input  logic [63:0]             d,
  output logic [gncl_pkg::QW-1:0] q,
  output logic                    done
);
  import gncl_pkg::*;

  localparam int NW = 64 + FRAC_BITS;
  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] nb_r;
  logic [63:0]   d_r, rem_r;
  logic [QW-1:0] q_r;
  logic          ovf_r, busy_r, done_r;
  logic [CW-1:0] cnt_r;
  logic [64:0]   rem_sh, diff;
  logic          ge;

  // one quotient bit per cycle
  always_comb begin
    rem_sh = {rem_r, nb_r[NW-1]};
    ge     = rem_sh >= {1'b0, d_r};
    diff   = rem_sh - {1'b0, d_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= short_mode ? CW'(32 + FRAC_BITS) : CW'(NW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // short mode: dividend known to fit 32 bits
  always_ff @(posedge clk) begin
    if (start) begin
      nb_r  <= short_mode ? {n[31:0], {(NW-32){1'b0}}} : {n, {FRAC_BITS{1'b0}}};
      d_r   <= d;
      rem_r <= '0;
      q_r   <= '0;
      ovf_r <= 1'b0;
    end else if (busy_r) begin
      nb_r  <= nb_r << 1;
      rem_r <= ge ? diff[63:0] : rem_sh[63:0];
      q_r   <= {q_r[QW-2:0], ge};
      ovf_r <= ovf_r | q_r[QW-1];
    end
  end

  assign q    = (ovf_r || q_r[QW-1]) ? {1'b1, {(QW-1){1'b0}}} : q_r;
  assign done = done_r;
endmodule

// ----- hw/rtl/gncl_dp.sv -----
// datapath: estimate, per-anchor terms, normal equations and shared units
module gncl_dp #(
  parameter int FRAC_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  gncl_pkg::gncl_cfg_t   cfg,
  input  gncl_pkg::gncl_in_t    in_item,
  input  gncl_pkg::gncl_cmd_t   cmd,
  output gncl_pkg::gncl_stat_t  st,
  output logic signed [31:0]    est_x,
  output logic signed [31:0]    est_y
);
  import gncl_pkg::*;

  localparam int JW = FRAC_BITS + 2;

  logic signed [31:0]        x_r, y_r, dx_r, dy_r;
  logic [63:0]               acc_r;
  logic [31:0]               d_r;
  logic signed [RES_W-1:0]   res_r [3];
  logic signed [JW-1:0]      jx_r [3];
  logic signed [JW-1:0]      jy_r [3];
  logic signed [63:0]        sxx_r, sxy_r, syy_r, gx_r, gy_r;
  logic signed [MUL_BW-1:0]  a11_r, a12_r, a22_r;
  logic signed [MUL_AW-1:0]  b1_r, b2_r;
  logic signed [63:0]        t_r, det_r, num_r;
  logic signed [QW:0]        vx_r, vy_r;

  logic [31:0]               mx, my;
  gncl_unit_t                unit;
  logic signed [MUL_AW-1:0]  mul_a;
  logic signed [MUL_BW-1:0]  mul_b;
  logic signed [63:0]        prod;
  logic                      mul_done, div_done, sqrt_done;
  logic [63:0]               div_n, div_d;
  logic                      div_short, div_neg;
  logic [QW-1:0]             quo;
  logic [31:0]               root;
  logic signed [QW:0]        q_signed;
  logic signed [JW-1:0]      j_signed;
  logic signed [RES_W-1:0]   res_new;
  logic signed [63:0]        sxx_sh, sxy_sh, syy_sh, nb1, nb2;

  assign mx   = abs32(dx_r);
  assign my   = abs32(dy_r);
  assign unit = op_unit(cmd.op);

  // multiplier operand selection
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      OP_SQX: begin mul_a = MUL_AW'(mx); mul_b = {1'b0, mx}; end
      OP_SQY: begin mul_a = MUL_AW'(my); mul_b = {1'b0, my}; end
      OP_SXX: begin mul_a = MUL_AW'(jx_r[cmd.sel]); mul_b = MUL_BW'(jx_r[cmd.sel]); end
      OP_SXY: begin mul_a = MUL_AW'(jx_r[cmd.sel]); mul_b = MUL_BW'(jy_r[cmd.sel]); end
      OP_SYY: begin mul_a = MUL_AW'(jy_r[cmd.sel]); mul_b = MUL_BW'(jy_r[cmd.sel]); end
      OP_GX:  begin mul_a = MUL_AW'(res_r[cmd.sel]); mul_b = MUL_BW'(jx_r[cmd.sel]); end
      OP_GY:  begin mul_a = MUL_AW'(res_r[cmd.sel]); mul_b = MUL_BW'(jy_r[cmd.sel]); end
      OP_DET1: begin mul_a = MUL_AW'(a22_r); mul_b = a11_r; end
      OP_DET2: begin mul_a = MUL_AW'(a12_r); mul_b = a12_r; end
      OP_NX1: begin mul_a = b1_r; mul_b = a22_r; end
      OP_NX2: begin mul_a = b2_r; mul_b = a12_r; end
      OP_NY1: begin mul_a = b2_r; mul_b = a11_r; end
      OP_NY2: begin mul_a = b1_r; mul_b = a12_r; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  // divider operand selection and sign of the quotient
  always_comb begin
    case (cmd.op)
      OP_JX: begin
        div_n = 64'(mx); div_d = 64'(d_r); div_short = 1'b1; div_neg = dx_r[31];
      end
      OP_JY: begin
        div_n = 64'(my); div_d = 64'(d_r); div_short = 1'b1; div_neg = dy_r[31];
      end
      default: begin
        div_n = abs64(num_r); div_d = abs64(det_r); div_short = 1'b0;
        div_neg = num_r[63] ^ det_r[63];
      end
    endcase
  end

  gncl_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.launch && unit == U_MUL),
    .a     (mul_a),
    .b     (mul_b),
    .p     (prod),
    .done  (mul_done)
  );

  gncl_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (cmd.launch && unit == U_DIV),
    .short_mode (div_short),
    .n          (div_n),
    .d          (div_d),
    .q          (quo),
    .done       (div_done)
  );

  gncl_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.launch && unit == U_SQRT),
    .v     (acc_r),
    .root  (root),
    .done  (sqrt_done)
  );

  // signed results and normalized terms
  always_comb begin
    q_signed = div_neg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
    j_signed = div_neg ? -$signed({1'b0, quo[JW-2:0]}) : $signed({1'b0, quo[JW-2:0]});
    res_new  = $signed({2'b00, d_r}) - $signed({3'b000, cfg.radius});
    sxx_sh   = sxx_r >>> FRAC_BITS;
    sxy_sh   = sxy_r >>> FRAC_BITS;
    syy_sh   = syy_r >>> FRAC_BITS;
    nb1      = -(gx_r >>> FRAC_BITS);
    nb2      = -(gy_r >>> FRAC_BITS);
  end

  // status back to the controller
  always_comb begin
    case (unit)
      U_MUL:   st.done = mul_done;
      U_DIV:   st.done = div_done;
      U_SQRT:  st.done = sqrt_done;
      default: st.done = 1'b1;
    endcase
    st.d_zero   = d_r == '0;
    st.det_zero = det_r == '0;
  end

  // write back of the finished operation
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_r <= in_item.start_x;
      y_r <= in_item.start_y;
    end else if (cmd.commit) begin
      case (cmd.op)
        OP_DIFF: begin
          dx_r <= sat32(64'(x_r) - 64'($signed(cfg.ax[cmd.sel])));
          dy_r <= sat32(64'(y_r) - 64'($signed(cfg.ay[cmd.sel])));
          if (cmd.sel == 2'd0) begin
            sxx_r <= '0; sxy_r <= '0; syy_r <= '0; gx_r <= '0; gy_r <= '0;
          end
        end
        OP_SQX:  acc_r <= 64'(prod);
        OP_SQY:  acc_r <= acc_r + 64'(prod);
        OP_ROOT: d_r <= root;
        OP_JX: begin
          jx_r[cmd.sel]  <= j_signed;
          res_r[cmd.sel] <= res_new;
        end
        OP_JY:   jy_r[cmd.sel] <= j_signed;
        OP_SXX:  sxx_r <= sxx_r + prod;
        OP_SXY:  sxy_r <= sxy_r + prod;
        OP_SYY:  syy_r <= syy_r + prod;
        OP_GX:   gx_r <= gx_r + prod;
        OP_GY:   gy_r <= gy_r + prod;
        OP_NORM: begin
          a11_r <= sxx_sh[MUL_BW-1:0];
          a12_r <= sxy_sh[MUL_BW-1:0];
          a22_r <= syy_sh[MUL_BW-1:0];
          b1_r  <= nb1[MUL_AW-1:0];
          b2_r  <= nb2[MUL_AW-1:0];
        end
        OP_DET1, OP_NX1, OP_NY1: t_r <= prod;
        OP_DET2: det_r <= t_r - prod;
        OP_NX2, OP_NY2: num_r <= t_r - prod;
        OP_DVX:  vx_r <= q_signed;
        OP_DVY:  vy_r <= q_signed;
        OP_UPD: begin
          x_r <= sat32(64'(x_r) + 64'(vx_r));
          y_r <= sat32(64'(y_r) + 64'(vy_r));
        end
        default: ;
      endcase
    end
  end

  assign est_x = x_r;
  assign est_y = y_r;
endmodule

// ----- hw/rtl/gncl_ctrl.sv -----
// controller: sequences the operations of each iteration and the item handshakes
module gncl_ctrl #(
  parameter int MAX_ITER = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  output logic                  out_valid,
  input  logic                  out_stall,
  input  logic [4:0]            iters,
  input  gncl_pkg::gncl_stat_t  st,
  output gncl_pkg::gncl_cmd_t   cmd,
  output gncl_pkg::gncl_info_t  info
);
  import gncl_pkg::*;

  localparam int CAP = (MAX_ITER < RESULT_CAP) ? MAX_ITER : RESULT_CAP;
  localparam logic [4:0] CAP5 = 5'(CAP);

  gncl_state_t state_r, state_nxt;
  gncl_op_t    op_r, op_nxt;
  logic [1:0]  sel_r, sel_nxt;
  logic [3:0]  k_r, k_nxt, nm1_r, nm1_nxt;
  logic        sing_r, sing_nxt;
  logic [4:0]  n_eff;
  logic        bail, last;

  // iterations per run, zero taken as one, capped
  always_comb begin
    if (iters == 5'd0) n_eff = 5'd1;
    else if (iters > CAP5) n_eff = CAP5;
    else n_eff = iters;
  end

  // zero distance or zero determinant ends the run
  assign bail = (op_r == OP_JX && st.d_zero) || (op_r == OP_NX1 && st.det_zero);
  assign last = sing_r || (k_r == nm1_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    sel_nxt   = sel_r;
    k_nxt     = k_r;
    nm1_nxt   = nm1_r;
    sing_nxt  = sing_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_LAUNCH;
          op_nxt    = OP_DIFF;
          sel_nxt   = 2'd0;
          k_nxt     = 4'd0;
          sing_nxt  = 1'b0;
          nm1_nxt   = 4'(n_eff - 5'd1);
        end
      end
      ST_LAUNCH: begin
        if (bail) begin
          sing_nxt  = 1'b1;
          state_nxt = ST_OUT;
        end else begin
          state_nxt = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (st.done) begin
          state_nxt = ST_LAUNCH;
          case (op_r)
            OP_DIFF: op_nxt = OP_SQX;
            OP_SQX:  op_nxt = OP_SQY;
            OP_SQY:  op_nxt = OP_ROOT;
            OP_ROOT: op_nxt = OP_JX;
            OP_JX:   op_nxt = OP_JY;
            OP_JY: begin
              if (sel_r == ANCHOR_LAST) begin
                sel_nxt = 2'd0;
                op_nxt  = OP_SXX;
              end else begin
                sel_nxt = sel_r + 2'd1;
                op_nxt  = OP_DIFF;
              end
            end
            OP_SXX:  op_nxt = OP_SXY;
            OP_SXY:  op_nxt = OP_SYY;
            OP_SYY:  op_nxt = OP_GX;
            OP_GX:   op_nxt = OP_GY;
            OP_GY: begin
              if (sel_r == ANCHOR_LAST) begin
                sel_nxt = 2'd0;
                op_nxt  = OP_NORM;
              end else begin
                sel_nxt = sel_r + 2'd1;
                op_nxt  = OP_SXX;
              end
            end
            OP_NORM: op_nxt = OP_DET1;
            OP_DET1: op_nxt = OP_DET2;
            OP_DET2: op_nxt = OP_NX1;
            OP_NX1:  op_nxt = OP_NX2;
            OP_NX2:  op_nxt = OP_DVX;
            OP_DVX:  op_nxt = OP_NY1;
            OP_NY1:  op_nxt = OP_NY2;
            OP_NY2:  op_nxt = OP_DVY;
            OP_DVY:  op_nxt = OP_UPD;
            OP_UPD:  state_nxt = ST_OUT;
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_OUT: begin
        if (!out_stall) begin
          if (last) begin
            state_nxt = ST_IDLE;
          end else begin
            state_nxt = ST_LAUNCH;
            op_nxt    = OP_DIFF;
            sel_nxt   = 2'd0;
            k_nxt     = k_r + 4'd1;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_stall   = state_r != ST_IDLE;
    out_valid  = state_r == ST_OUT;
    cmd.op     = op_r;
    cmd.sel    = sel_r;
    cmd.load   = state_r == ST_IDLE && in_valid;
    cmd.launch = state_r == ST_LAUNCH && !bail;
    cmd.commit = state_r == ST_WAIT && st.done;
    info.idx   = k_r;
    info.sing  = sing_r;
    info.last  = last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      op_r    <= OP_DIFF;
      sel_r   <= '0;
      k_r     <= '0;
      nm1_r   <= '0;
      sing_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
      sel_r   <= sel_nxt;
      k_r     <= k_nxt;
      nm1_r   <= nm1_nxt;
      sing_r  <= sing_nxt;
    end
  end
endmodule

// ----- hw/rtl/gauss_newton_circle_locator.sv -----
// Gauss-Newton circle locator: one item in, one result per iteration out.
// At FRAC_BITS=16 an iteration uses three 32-step square roots, six 48-step
// and two 80-step divides on one shared divider, and 27 multiplies.
// Each operation passes through a launch state and a wait state, and each result
// is offered from an output state; output stalls lengthen a run; one item at a time.
// Synchronous active-low reset idles the block and loads the default anchors,
// radius 1.0 and 10 iterations; there is no clearing pass.
module gauss_newton_circle_locator #(
  parameter int FRAC_BITS = 16,
  parameter int MAX_ITER  = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  gncl_pkg::gncl_in_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output gncl_pkg::gncl_out_t  out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [2:0]           cfg_index,
  input  logic [31:0]          cfg_data
);
  import gncl_pkg::*;

  localparam logic [31:0] FX_ONE = 32'(1) << FRAC_BITS;

  gncl_cfg_t        cfg_r;
  gncl_cmd_t        cmd;
  gncl_stat_t       st;
  gncl_info_t       info;
  logic signed [31:0] est_x, est_y;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ax     <= {FX_ONE, FX_ONE, 32'(-FX_ONE)};
      cfg_r.ay     <= {32'(-FX_ONE), FX_ONE, 32'd0};
      cfg_r.radius <= 31'(FX_ONE);
      cfg_r.iters  <= 5'd10;
    end else if (cfg_valid && cfg_ready) begin
      case (gncl_reg_t'(cfg_index))
        REG_A_X:  cfg_r.ax[0]  <= cfg_data;
        REG_A_Y:  cfg_r.ay[0]  <= cfg_data;
        REG_B_X:  cfg_r.ax[1]  <= cfg_data;
        REG_B_Y:  cfg_r.ay[1]  <= cfg_data;
        REG_C_X:  cfg_r.ax[2]  <= cfg_data;
        REG_C_Y:  cfg_r.ay[2]  <= cfg_data;
        REG_RAD:  cfg_r.radius <= cfg_data[30:0];
        REG_ITER: cfg_r.iters  <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  gncl_ctrl #(.MAX_ITER(MAX_ITER)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .iters     (cfg_r.iters),
    .st        (st),
    .cmd       (cmd),
    .info      (info)
  );

  gncl_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .in_item (in_data),
    .cmd     (cmd),
    .st      (st),
    .est_x   (est_x),
    .est_y   (est_y)
  );

  // result item
  always_comb begin
    out_data.est_x           = est_x;
    out_data.est_y           = est_y;
    out_data.iteration_index = info.idx;
    out_data.singular        = info.sing;
    out_data.last_result     = info.last;
  end
endmodule

// ----- tb/testbench.sv -----
// self-checking testbench for the gauss-newton circle locator
module testbench;
  import gncl_pkg::*;

  localparam int STALL_LIMIT = 40000;
  localparam int SETTLE      = 40;

  // holds the expected estimates and the block's register copy
  class estimate_board;
    longint ax[3], ay[3];
    longint radius;
    int     iters;
    gncl_out_t due[$];
    int     fails;

    function new();
      ax = '{-65536, 65536, 65536};
      ay = '{0, 65536, -65536};
      radius = 65536;
      iters = 10;
      fails = 0;
    endfunction

    function void report(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      fails++;
    endfunction

    function void configure(gncl_reg_t idx, logic [31:0] v);
      case (idx)
        REG_A_X: ax[0] = longint'($signed(v));
        REG_A_Y: ay[0] = longint'($signed(v));
        REG_B_X: ax[1] = longint'($signed(v));
        REG_B_Y: ay[1] = longint'($signed(v));
        REG_C_X: ax[2] = longint'($signed(v));
        REG_C_Y: ay[2] = longint'($signed(v));
        REG_RAD: radius = longint'(v[30:0]);
        REG_ITER: iters = int'(v[4:0]);
        default: ;
      endcase
    endfunction

    function longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    // integer square root, floor
    function longint root64(longint unsigned n);
      longint unsigned acc, b;
      acc = 0;
      b = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
        if (n >= acc + b) begin
          n = n - (acc + b);
          acc = (acc >> 1) + b;
        end else begin
          acc = acc >> 1;
        end
        b = b >> 2;
      end
      return longint'(acc);
    endfunction

    // num * 2^16 / den toward zero, magnitude capped at 2^40
    function longint step_div(longint num, longint den);
      bit neg;
      longint unsigned n, d, q, r;
      neg = (num < 0) != (den < 0);
      n = num < 0 ? -num : num;
      d = den < 0 ? -den : den;
      q = n / d;
      r = n % d;
      if (q >= (64'd1 << 24)) begin
        q = 64'd1 << 40;
      end else begin
        for (int i = 0; i < 16; i++) begin
          r = r << 1;
          q = q << 1;
          if (r >= d) begin
            r = r - d;
            q = q | 1;
          end
        end
      end
      return neg ? -longint'(q) : longint'(q);
    endfunction

    // one gauss-newton step, returns 0 when the system cannot be solved
    function bit refine(inout longint x, inout longint y);
      longint jx[3], jy[3], rs[3];
      longint dx, dy, d, sxx, sxy, syy, gx, gy, a11, a12, a22, b1, b2, det;
      longint unsigned mx, my;
      sxx = 0; sxy = 0; syy = 0; gx = 0; gy = 0;
      for (int i = 0; i < 3; i++) begin
        dx = clamp32(x - ax[i]);
        dy = clamp32(y - ay[i]);
        mx = dx < 0 ? -dx : dx;
        my = dy < 0 ? -dy : dy;
        d = root64(mx * mx + my * my);
        if (d == 0) return 0;
        rs[i] = d - radius;
        jx[i] = (dx * 65536) / d;
        jy[i] = (dy * 65536) / d;
      end
      for (int i = 0; i < 3; i++) begin
        sxx += jx[i] * jx[i];
        sxy += jx[i] * jy[i];
        syy += jy[i] * jy[i];
        gx += jx[i] * rs[i];
        gy += jy[i] * rs[i];
      end
      a11 = sxx >>> 16;
      a12 = sxy >>> 16;
      a22 = syy >>> 16;
      b1 = -(gx >>> 16);
      b2 = -(gy >>> 16);
      det = a11 * a22 - a12 * a12;
      if (det == 0) return 0;
      x = clamp32(x + step_div(a22 * b1 - a12 * b2, det));
      y = clamp32(y + step_div(a11 * b2 - a12 * b1, det));
      return 1;
    endfunction

    // an accepted start point: queue the estimate of every iteration
    function void note_start(gncl_in_t s);
      longint x, y;
      int n;
      gncl_out_t o;
      x = longint'(s.start_x);
      y = longint'(s.start_y);
      n = iters == 0 ? 1 : (iters > 16 ? 16 : iters);
      for (int k = 0; k < n; k++) begin
        o.singular = !refine(x, y);
        o.est_x = x[31:0];
        o.est_y = y[31:0];
        o.iteration_index = k[3:0];
        o.last_result = o.singular || (k == n - 1);
        due.push_back(o);
        if (o.singular) break;
      end
    endfunction

    function void check(gncl_out_t got);
      gncl_out_t w;
      if (due.size() == 0) begin
        report($sformatf("unexpected result %h", got));
        return;
      end
      w = due.pop_front();
      if (got.est_x !== w.est_x)
        report($sformatf("est_x %h, want %h", got.est_x, w.est_x));
      if (got.est_y !== w.est_y)
        report($sformatf("est_y %h, want %h", got.est_y, w.est_y));
      if (got.iteration_index !== w.iteration_index)
        report($sformatf("iteration_index %0d, want %0d", got.iteration_index,
                         w.iteration_index));
      if (got.singular !== w.singular)
        report($sformatf("singular %b, want %b", got.singular, w.singular));
      if (got.last_result !== w.last_result)
        report($sformatf("last_result %b, want %b", got.last_result, w.last_result));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  gncl_in_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  gncl_out_t   out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  estimate_board board = new();
  bit calm = 1'b0;
  int quiet_cycles = 0;

  gauss_newton_circle_locator i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  // monitors on both channels
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) board.note_start(in_data);
    if (rst_n && out_valid && !out_stall) board.check(out_data);
  end

  // receiver stalls at random outside the quiet stretch
  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(99) < 16);
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic write_reg(gncl_reg_t idx, logic [31:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    board.configure(idx, v);
  endtask

  task automatic send_start(logic [31:0] x, logic [31:0] y);
    gncl_in_t s;
    // no register write while a run is in flight
    cfg_valid <= 1'b0;
    if (!calm && $urandom_range(99) < 16) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    s.start_x = x;
    s.start_y = y;
    in_valid <= 1'b1;
    in_data <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // wait until every expected estimate has come and the block is idle
  task automatic drain();
    in_valid <= 1'b0;
    cfg_valid <= 1'b0;
    @(posedge clk);
    while (board.due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic logic [31:0] near_coord();
    return 32'($signed($urandom_range(0, 16 * 65536)) - 8 * 65536);
  endfunction

  task automatic write_anchors(bit wide);
    for (int r = 0; r < 6; r++)
      write_reg(gncl_reg_t'(r), wide ? $urandom() : near_coord());
  endtask

  initial begin
    int n;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // default anchors, short runs, field extremes and a zero distance
    write_reg(REG_ITER, 32'd3);
    send_start(32'd0, 32'd0);
    send_start(32'hFFFF_0000, 32'd0);
    send_start(32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_start(32'h8000_0000, 32'h8000_0000);
    send_start(32'h7FFF_FFFF, 32'h8000_0000);
    send_start(32'h0001_2345, 32'hFFFF_6789);
    send_start(32'd1, 32'hFFFF_FFFF);
    drain();
    // zero count does one iteration, oversized count is capped
    write_reg(REG_ITER, 32'd0);
    send_start(32'd0, 32'd0);
    drain();
    write_reg(REG_ITER, 32'd31);
    send_start(32'd0, 32'h0000_8000);
    drain();
    // coincident anchors give a zero determinant
    write_reg(REG_ITER, 32'd2);
    for (int r = 0; r < 6; r++) write_reg(gncl_reg_t'(r), 32'd0);
    write_reg(REG_RAD, 32'd0);
    send_start(32'h0001_0000, 32'h0001_0000);
    send_start(32'd0, 32'd0);
    drain();
    // extreme anchors and radius
    write_reg(REG_A_X, 32'h8000_0000);
    write_reg(REG_A_Y, 32'h7FFF_FFFF);
    write_reg(REG_B_X, 32'h7FFF_FFFF);
    write_reg(REG_B_Y, 32'h8000_0000);
    write_reg(REG_C_X, 32'h7FFF_FFFF);
    write_reg(REG_C_Y, 32'h7FFF_FFFF);
    write_reg(REG_RAD, 32'h7FFF_FFFF);
    send_start(32'd0, 32'd0);
    send_start(32'h8000_0000, 32'h7FFF_FFFF);
    drain();

    // random phases, each with fresh registers
    for (int ph = 0; ph < 12; ph++) begin
      calm = (ph == 4);
      write_anchors($urandom_range(99) < 20);
      case ($urandom_range(3))
        0: write_reg(REG_RAD, 32'd0);
        1: write_reg(REG_RAD, {1'b0, 31'h7FFF_FFFF});
        default: write_reg(REG_RAD, $urandom_range(0, 6 * 65536));
      endcase
      if (ph == 7) write_reg(REG_ITER, 32'd16);
      else if (ph == 9) write_reg(REG_ITER, $urandom_range(0, 31));
      else write_reg(REG_ITER, $urandom_range(1, 3));
      n = board.iters > 4 ? 8 : 36;
      for (int k = 0; k < n; k++) begin
        if ($urandom_range(99) < 12)
          send_start($urandom(), $urandom());
        else if ($urandom_range(99) < 4)
          send_start(32'(board.ax[k % 3]), 32'(board.ay[k % 3]));
        else
          send_start(near_coord(), near_coord());
      end
      drain();
    end

    if (board.fails == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule

// ----- sim.f -----
hw/rtl/gncl_pkg.sv
hw/rtl/gncl_mul.sv
hw/rtl/gncl_sqrt.sv
hw/rtl/gncl_div.sv
hw/rtl/gncl_dp.sv
hw/rtl/gncl_ctrl.sv
hw/rtl/gauss_newton_circle_locator.sv
tb/testbench.sv
